// ===== src/idr_pkg.sv =====
// idr_pkg: shared constants and sequencer state type for the 64-bit divider.
// Used by int64_divide_remainder. No dependencies.

package idr_pkg;

    // Operand width of the divider core. Port widths stay at 64 bits.
    localparam int DATA_WIDTH = 64;
    localparam int CNT_W      = $clog2(DATA_WIDTH);
    localparam int PORT_W     = 64;

    // Value of the op field
    localparam logic OP_UNSIGNED = 1'b0;
    localparam logic OP_SIGNED   = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_NEG_A,
        S_NEG_B,
        S_DIV,
        S_NEG_Q,
        S_NEG_R,
        S_DONE
    } state_t;

endpackage

// ===== src/int64_divide_remainder.sv =====
// int64_divide_remainder: restoring shift-subtract divider giving quotient and remainder.
// Depends on idr_pkg (width constants, sequencer state type).

// One request at a time goes through a single shared (DATA_WIDTH+1)-bit subtractor.
// Sequence: take the operands, negate the dividend and then the divisor if they
// are negative (signed mode only has effect), run the restoring division loop
// (one quotient bit a cycle), negate quotient and remainder as the signs
// require, then load the output register. s_tready is high only while the
// sequencer is idle, which it reaches on the same edge that raises m_tvalid,
// so a new request is accepted only once the previous one has reached the
// output register. The output register holds a finished result until it is
// taken, so the next request may already be accepted and worked on; that
// request waits in its last step only if the previous result is still unread.
// Signed mode divides magnitudes, truncating toward zero: the quotient is negated
// when the operand signs differ and the remainder follows the dividend's sign.
// The most negative value divided by minus one wraps to the most negative value.
// A zero divisor gives quotient and remainder of zero with m_tuser (divide_by_zero)
// set. Only the low DATA_WIDTH bits of the operands are used; results are
// zero-extended to 64 bits.

module int64_divide_remainder (
    input  logic         aclk,
    input  logic         aresetn,
    // request channel
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [127:0] s_tdata,   // [63:0] dividend, [127:64] divisor
    input  logic         s_tuser,   // [0] op (0 unsigned, 1 signed)
    // result channel
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [127:0] m_tdata,   // [63:0] quotient, [127:64] remainder
    output logic         m_tuser    // [0] divide_by_zero
);
    import idr_pkg::*;

    localparam int W = DATA_WIDTH;

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg,   cnt_next;
    logic [W-1:0]     a_reg,     a_next;    // dividend, shifts into quotient
    logic [W-1:0]     b_reg,     b_next;    // divisor magnitude
    logic [W-1:0]     p_reg,     p_next;    // partial remainder
    logic             an_reg,    an_next;   // dividend negative (signed mode)
    logic             bn_reg,    bn_next;   // divisor negative (signed mode)
    logic             dz_reg,    dz_next;
    logic             mv_reg,    mv_next;
    logic [W-1:0]     q_out_reg, q_out_next;
    logic [W-1:0]     r_out_reg, r_out_next;
    logic             dz_out_reg, dz_out_next;

    // shared subtractor
    logic [W:0] sub_x, sub_y, diff;
    logic       take;
    logic       accept;
    logic       out_free;
    logic [W-1:0] in_a, in_b;

    assign in_a     = s_tdata[W-1:0];
    assign in_b     = s_tdata[PORT_W+W-1:PORT_W];
    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign out_free = !mv_reg || m_tready;
    assign diff     = sub_x - sub_y;
    assign take     = !diff[W];

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:  if (accept) state_next = S_NEG_A;
            S_NEG_A: state_next = S_NEG_B;
            S_NEG_B: state_next = S_DIV;
            S_DIV:   if (cnt_reg == '0) state_next = S_NEG_Q;
            S_NEG_Q: state_next = S_NEG_R;
            S_NEG_R: state_next = S_DONE;
            S_DONE:  if (out_free) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        cnt_next    = cnt_reg;
        a_next      = a_reg;
        b_next      = b_reg;
        p_next      = p_reg;
        an_next     = an_reg;
        bn_next     = bn_reg;
        dz_next     = dz_reg;
        q_out_next  = q_out_reg;
        r_out_next  = r_out_reg;
        dz_out_next = dz_out_reg;
        mv_next     = mv_reg && !m_tready;
        sub_x       = '0;
        sub_y       = '0;
        case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    a_next   = in_a;
                    b_next   = in_b;
                    p_next   = '0;
                    an_next  = (s_tuser == OP_SIGNED) && in_a[W-1];
                    bn_next  = (s_tuser == OP_SIGNED) && in_b[W-1];
                    dz_next  = (in_b == '0);
                    cnt_next = CNT_W'(W - 1);
                end
            end
            S_NEG_A: begin
                sub_y = {1'b0, a_reg};
                if (an_reg) a_next = diff[W-1:0];
            end
            S_NEG_B: begin
                sub_y = {1'b0, b_reg};
                if (bn_reg) b_next = diff[W-1:0];
            end
            S_DIV: begin
                // shift in next dividend bit; a set top bit means part is below divisor
                sub_x = {p_reg, a_reg[W-1]};
                sub_y = {1'b0, b_reg};
                p_next   = take ? diff[W-1:0] : {p_reg[W-2:0], a_reg[W-1]};
                a_next   = {a_reg[W-2:0], take};
                cnt_next = cnt_reg - CNT_W'(1);
            end
            S_NEG_Q: begin
                sub_y = {1'b0, a_reg};
                if (an_reg != bn_reg) a_next = diff[W-1:0];
            end
            S_NEG_R: begin
                sub_y = {1'b0, p_reg};
                if (an_reg) p_next = diff[W-1:0];
            end
            S_DONE: begin
                if (out_free) begin
                    mv_next     = 1'b1;
                    q_out_next  = dz_reg ? '0 : a_reg;
                    r_out_next  = dz_reg ? '0 : p_reg;
                    dz_out_next = dz_reg;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            mv_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            mv_reg    <= mv_next;
        end
    end

    always_ff @(posedge aclk) begin
        cnt_reg    <= cnt_next;
        a_reg      <= a_next;
        b_reg      <= b_next;
        p_reg      <= p_next;
        an_reg     <= an_next;
        bn_reg     <= bn_next;
        dz_reg     <= dz_next;
        q_out_reg  <= q_out_next;
        r_out_reg  <= r_out_next;
        dz_out_reg <= dz_out_next;
    end

    assign m_tvalid = mv_reg;
    assign m_tdata  = {PORT_W'(r_out_reg), PORT_W'(q_out_reg)};
    assign m_tuser  = dz_out_reg;

    // checks
    a_dz_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (mv_reg && dz_out_reg) |-> (q_out_reg == '0 && r_out_reg == '0))
        else $error("divide-by-zero result not zero");

    a_accept_start: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> (state_reg == S_NEG_A))
        else $error("accepted request did not start sequence");

    a_div_end: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_DIV && cnt_reg == '0) |=> (state_reg == S_NEG_Q))
        else $error("division loop overran");

    a_load_done: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(mv_reg) |-> $past(state_reg == S_DONE))
        else $error("output loaded outside done step");

endmodule
